>>> src/dns_pkg.sv
// Shared types, codes and constants for the decimal number scanner.
package dns_pkg;

	localparam int DEF_VALUE_BITS      = 48;
	localparam int DEF_MAX_FRAC_DIGITS = 6;

	localparam int CH_W     = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;
	localparam int LIMIT_W  = 3;
	localparam int ADD_W    = 34;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(6);
	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

	localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CHAR_DOT   = 8'h2e;
	localparam logic [CH_W-1:0] CHAR_PLUS  = 8'h2b;
	localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2d;

	typedef enum logic [2:0] {
		PH_BEGIN,
		PH_SIGN,
		PH_DOT,
		PH_INTEGER,
		PH_FRACTION
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_NO_FRAC_DIGIT,
		ST_NO_SIGN_DIGIT,
		ST_BAD_FIRST
	} status_t;

	// control into the saturating multiply-add
	typedef struct packed {
		logic times_ten;
		logic saturated;
	} acc_ctl_t;

	function automatic logic [ADD_W-1:0] pow10(input logic [3:0] e);
		logic [ADD_W-1:0] p;
		case (e)
			4'd0: p = ADD_W'(1);
			4'd1: p = ADD_W'(10);
			4'd2: p = ADD_W'(100);
			4'd3: p = ADD_W'(1000);
			4'd4: p = ADD_W'(10000);
			4'd5: p = ADD_W'(100000);
			4'd6: p = ADD_W'(1000000);
			4'd7: p = ADD_W'(10000000);
			4'd8: p = ADD_W'(100000000);
			4'd9: p = ADD_W'(1000000000);
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

>>> src/dns_char_if.sv
// Character channel: valid/ready handshake carrying one ASCII byte.
interface dns_char_if;
	logic                   valid;
	logic                   ready;
	logic [dns_pkg::CH_W-1:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

>>> src/dns_result_if.sv
// Result channel: valid/ready handshake carrying one scanned number.
interface dns_result_if #(
	parameter int VALUE_BITS = dns_pkg::DEF_VALUE_BITS
);
	logic                          valid;
	logic                          ready;
	logic [dns_pkg::STATUS_W-1:0]  status;
	logic signed [VALUE_BITS-1:0]  value;
	logic [dns_pkg::COUNT_W-1:0]   char_count;
	logic                          overflow;

	modport source (output valid, output status, output value, output char_count,
		output overflow, input ready);
	modport sink   (input valid, input status, input value, input char_count,
		input overflow, output ready);
endinterface

>>> src/decimal_number_scanner.sv
// Top level of the decimal number scanner: input register, limit register, scan core.
//
// Feed ASCII characters on chars, one item per handshake. The block scans an
// optional sign, integer digits, an optional point and fraction digits, and
// delivers one item on results when the number ends or is malformed: status,
// value (signed, scaled by 10^MAX_FRAC_DIGITS), char_count and overflow.
// The character that ends a number is dropped, not rescanned.
// Write cfg_wr_data with cfg_wr_en high to set the fraction digit limit;
// do so only while no characters are in flight.
// A character accepted into the input register is scanned from there into the
// scan state and, when it ends a number, into the result register.
// Throughput: one character per cycle while no result item waits on a low
// results.ready; the scan step and the multiply-add of the magnitude are both
// combinational between the input register and the result register.
// Reset clears the scan state, empties both registers and sets the limit to 6.
// When results.ready is low with an item waiting, the scan holds and
// chars.ready falls once the input register is also full; nothing is lost.
module decimal_number_scanner #(
	parameter int VALUE_BITS      = dns_pkg::DEF_VALUE_BITS,
	parameter int MAX_FRAC_DIGITS = dns_pkg::DEF_MAX_FRAC_DIGITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [dns_pkg::LIMIT_W-1:0] cfg_wr_data,
	dns_char_if.sink                    chars,
	dns_result_if.source                results
);
	import dns_pkg::*;

	logic              valid_s1;
	logic [CH_W-1:0]   ch_s1;
	logic              step_ready;
	logic [LIMIT_W-1:0] limit_q;

	assign chars.ready = !valid_s1 || step_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1 <= chars.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	dns_scan #(
		.VALUE_BITS      (VALUE_BITS),
		.MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_valid (valid_s1),
		.ch         (ch_s1),
		.limit      (limit_q),
		.step_ready (step_ready),
		.results    (results)
	);

endmodule

>>> src/dns_accum.sv
// Saturating magnitude update: mag * (10 or 1) + add, clamped to the maximum.
module dns_accum #(
	parameter int VALUE_BITS = dns_pkg::DEF_VALUE_BITS
) (
	input  dns_pkg::acc_ctl_t           ctl,
	input  logic [VALUE_BITS-2:0]       mag,
	input  logic [dns_pkg::ADD_W-1:0]   add,
	output logic [VALUE_BITS-2:0]       mag_next,
	output logic                        sat_next
);
	import dns_pkg::*;

	localparam int MW = VALUE_BITS - 1;
	localparam int WW = VALUE_BITS + 4;
	localparam logic [MW-1:0] MAG_MAX   = '1;
	localparam logic [MW-1:0] MAG_DIV10 = MAG_MAX / 10;

	logic [WW-1:0] mag_w;
	logic [WW-1:0] scaled;
	logic [WW-1:0] sum;
	logic          over_pre;
	logic          over;

	assign mag_w  = WW'(mag);
	assign scaled = ctl.times_ten ? ((mag_w << 3) + (mag_w << 1)) : mag_w;
	assign sum    = scaled + WW'(add);

	assign over_pre = ctl.saturated || (WW'(add) > WW'(MAG_MAX))
		|| (ctl.times_ten && (mag > MAG_DIV10));
	assign over     = over_pre || (sum > WW'(MAG_MAX));

	assign mag_next = over ? MAG_MAX : sum[MW-1:0];
	assign sat_next = over;

endmodule

>>> src/dns_scan.sv
// Scan state, per-character phase logic and the result register.
module dns_scan #(
	parameter int VALUE_BITS      = dns_pkg::DEF_VALUE_BITS,
	parameter int MAX_FRAC_DIGITS = dns_pkg::DEF_MAX_FRAC_DIGITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_valid,
	input  logic [dns_pkg::CH_W-1:0]      ch,
	input  logic [dns_pkg::LIMIT_W-1:0]   limit,
	output logic                          step_ready,
	dns_result_if.source                  results
);
	import dns_pkg::*;

	localparam int MW = VALUE_BITS - 1;
	localparam int FW = $clog2(MAX_FRAC_DIGITS + 1);
	localparam logic [MW-1:0] MAG_MAX = '1;

	phase_t               phase_q, phase_d;
	logic [MW-1:0]        mag_q;
	logic                 neg_q;
	logic [FW-1:0]        seen_q;
	logic [COUNT_W-1:0]   consumed_q;
	logic                 sat_q;

	logic                 res_valid_q;
	status_t              res_status_q;
	logic signed [VALUE_BITS-1:0] res_value_q;
	logic [COUNT_W-1:0]   res_count_q;
	logic                 res_ovf_q;

	logic                 step_en;
	logic                 dig;
	logic [3:0]           digit;
	logic [FW-1:0]        eff_limit;
	logic [3:0]           frac_exp;
	logic [ADD_W-1:0]     add;

	// decoded actions for the current character
	logic                 do_emit;
	status_t              emit_status;
	logic                 do_count;
	logic                 do_acc;
	logic                 acc_frac;
	logic                 do_sign;

	acc_ctl_t             acc_ctl;
	logic [MW-1:0]        mag_next;
	logic                 sat_next;
	logic [VALUE_BITS-1:0] mag_ext;

	assign step_ready = !res_valid_q || results.ready;
	assign step_en    = step_valid && step_ready;

	assign dig   = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
	assign digit = dig ? 4'(ch - CHAR_ZERO) : 4'd0;

	always_comb begin
		if (limit == '0) begin
			eff_limit = FW'(1);
		end else if (int'(limit) > MAX_FRAC_DIGITS) begin
			eff_limit = FW'(MAX_FRAC_DIGITS);
		end else begin
			eff_limit = FW'(limit);
		end
	end

	assign frac_exp = acc_frac ? 4'(MAX_FRAC_DIGITS - 1 - int'(seen_q))
		: 4'(MAX_FRAC_DIGITS);
	assign add      = ADD_W'(digit * pow10(frac_exp));

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_SIGN, PH_INTEGER: begin
				if (ch == CHAR_DOT) begin
					phase_d = PH_DOT;
				end else if (dig) begin
					phase_d = PH_INTEGER;
				end else begin
					phase_d = PH_BEGIN;
				end
			end
			PH_DOT: begin
				phase_d = dig ? PH_FRACTION : PH_BEGIN;
			end
			PH_FRACTION: begin
				phase_d = (dig && (seen_q < eff_limit)) ? PH_FRACTION : PH_BEGIN;
			end
			default: begin
				if (dig) begin
					phase_d = PH_INTEGER;
				end else if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
					phase_d = PH_SIGN;
				end else if (ch == CHAR_DOT) begin
					phase_d = PH_DOT;
				end else begin
					phase_d = PH_BEGIN;
				end
			end
		endcase
	end

	// actions
	always_comb begin
		do_emit     = 1'b0;
		emit_status = ST_OK;
		do_count    = 1'b0;
		do_acc      = 1'b0;
		acc_frac    = 1'b0;
		do_sign     = 1'b0;
		case (phase_q)
			PH_SIGN: begin
				if (ch == CHAR_DOT) begin
					do_count = 1'b1;
				end else if (dig) begin
					do_count = 1'b1;
					do_acc   = 1'b1;
				end else begin
					do_emit     = 1'b1;
					emit_status = ST_NO_SIGN_DIGIT;
				end
			end
			PH_DOT: begin
				if (dig) begin
					do_count = 1'b1;
					do_acc   = 1'b1;
					acc_frac = 1'b1;
				end else begin
					do_emit     = 1'b1;
					emit_status = ST_NO_FRAC_DIGIT;
				end
			end
			PH_INTEGER: begin
				if (ch == CHAR_DOT) begin
					do_count = 1'b1;
				end else if (dig) begin
					do_count = 1'b1;
					do_acc   = 1'b1;
				end else begin
					do_emit = 1'b1;
				end
			end
			PH_FRACTION: begin
				if (dig && (seen_q < eff_limit)) begin
					do_count = 1'b1;
					do_acc   = 1'b1;
					acc_frac = 1'b1;
				end else begin
					do_emit = 1'b1;
				end
			end
			default: begin
				if (dig) begin
					do_count = 1'b1;
					do_acc   = 1'b1;
				end else if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
					do_count = 1'b1;
					do_sign  = 1'b1;
				end else if (ch == CHAR_DOT) begin
					do_count = 1'b1;
				end else begin
					do_emit     = 1'b1;
					emit_status = ST_BAD_FIRST;
				end
			end
		endcase
	end

	assign acc_ctl.times_ten = !acc_frac;
	assign acc_ctl.saturated = sat_q;

	dns_accum #(
		.VALUE_BITS (VALUE_BITS)
	) u_accum (
		.ctl      (acc_ctl),
		.mag      (mag_q),
		.add      (add),
		.mag_next (mag_next),
		.sat_next (sat_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_BEGIN;
			mag_q      <= '0;
			neg_q      <= 1'b0;
			seen_q     <= '0;
			consumed_q <= '0;
			sat_q      <= 1'b0;
		end else if (step_en) begin
			if (do_emit) begin
				phase_q    <= PH_BEGIN;
				mag_q      <= '0;
				neg_q      <= 1'b0;
				seen_q     <= '0;
				consumed_q <= '0;
				sat_q      <= 1'b0;
			end else begin
				phase_q <= phase_d;
				if (do_acc) begin
					mag_q <= mag_next;
					sat_q <= sat_next;
				end
				if (acc_frac) begin
					seen_q <= seen_q + FW'(1);
				end
				if (do_sign) begin
					neg_q <= (ch == CHAR_MINUS);
				end
				if (do_count && consumed_q != COUNT_MAX) begin
					consumed_q <= consumed_q + COUNT_W'(1);
				end
			end
		end
	end

	assign mag_ext = VALUE_BITS'(mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_en && do_emit) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && do_emit) begin
			res_status_q <= emit_status;
			res_count_q  <= consumed_q;
			if (emit_status == ST_OK) begin
				res_value_q <= neg_q ? -$signed(mag_ext) : $signed(mag_ext);
				res_ovf_q   <= sat_q;
			end else begin
				res_value_q <= '0;
				res_ovf_q   <= 1'b0;
			end
		end
	end

	assign results.valid      = res_valid_q;
	assign results.status     = res_status_q;
	assign results.value      = res_value_q;
	assign results.char_count = res_count_q;
	assign results.overflow   = res_ovf_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_status_q != ST_OK |-> res_value_q == '0 && !res_ovf_q)
		else $error("error item carries a nonzero value or overflow");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> mag_q == MAG_MAX)
		else $error("saturated flag without maximum magnitude");

	a_frac_seen: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FRACTION |-> seen_q != '0 && int'(seen_q) <= MAX_FRAC_DIGITS)
		else $error("fraction digit count out of range");

	a_begin_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BEGIN |-> mag_q == '0 && consumed_q == '0 && !neg_q && !sat_q)
		else $error("begin phase with leftover number state");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && do_emit |=> res_valid_q)
		else $error("terminated number produced no item");

endmodule
